FILE: sv/gbcd_pkg.sv
// Shared types, codes and constants of the gyro bias calibration block.
package gbcd_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] REG_SAMPLE_COUNT   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_SIGMA_MULTIPLE = 2'd1;
    localparam logic [CFG_AW-1:0] REG_SENSITIVITY    = 2'd2;

    localparam logic [12:0] SAMPLE_COUNT_RST   = 13'd1024;
    localparam logic [3:0]  SIGMA_MULTIPLE_RST = 4'd3;
    localparam logic [15:0] SENSITIVITY_RST    = 16'd573;

    localparam int RAW_W  = 16;
    localparam int RATE_W = 22;
    localparam int ZR_W   = 24;
    localparam int DB_W   = 28;
    localparam int ROOT_W = 24;
    localparam int VAR_W  = 2 * ROOT_W;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_ACCUM,
        OP_MEAN_LD,
        OP_DIV_STEP,
        OP_MEAN_WR,
        OP_MUL_STEP,
        OP_SQ,
        OP_DIFF_LD,
        OP_DIV2_LD,
        OP_SQRT_LD,
        OP_SQRT_STEP,
        OP_DB_WR,
        OP_FINISH,
        OP_MEAS1,
        OP_MEAS2,
        OP_OUT_CAL,
        OP_OUT_MEAS
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic finish;
        logic step_last;
        logic out_free;
    } t_stat;

endpackage

FILE: sv/gbcd_ctrl.sv
// Sequencer of the gyro bias calibration block: issues datapath commands.
module gbcd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_mode,
    output logic            o_in_ready,
    input  gbcd_pkg::t_stat i_stat,
    output gbcd_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_ACC, S_CHK, S_LDMEAN, S_MEAN_RUN, S_MEAN_WR, S_MUL_RUN, S_SQ,
        S_DIFF, S_DIV1_RUN, S_DIV2, S_DIV2_RUN, S_ROOT, S_ROOT_RUN, S_DBW,
        S_FIN, S_OUT, S_MEAS1, S_MEAS2, S_MOUT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;
    gbcd_pkg::t_op w_op;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        w_op    = gbcd_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_op    = gbcd_pkg::OP_CAPTURE;
                    n_state = i_in_mode ? S_ACC : S_MEAS1;
                end
            end
            S_ACC: begin
                w_op    = gbcd_pkg::OP_ACCUM;
                n_state = S_CHK;
            end
            S_CHK: begin
                n_axis  = 2'd0;
                n_state = i_stat.finish ? S_LDMEAN : S_OUT;
            end
            S_LDMEAN: begin
                w_op    = gbcd_pkg::OP_MEAN_LD;
                n_state = S_MEAN_RUN;
            end
            S_MEAN_RUN: begin
                w_op = gbcd_pkg::OP_DIV_STEP;
                if (i_stat.step_last) n_state = S_MEAN_WR;
            end
            S_MEAN_WR: begin
                w_op    = gbcd_pkg::OP_MEAN_WR;
                n_state = S_MUL_RUN;
            end
            S_MUL_RUN: begin
                w_op = gbcd_pkg::OP_MUL_STEP;
                if (i_stat.step_last) n_state = S_SQ;
            end
            S_SQ: begin
                w_op    = gbcd_pkg::OP_SQ;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                w_op    = gbcd_pkg::OP_DIFF_LD;
                n_state = S_DIV1_RUN;
            end
            S_DIV1_RUN: begin
                w_op = gbcd_pkg::OP_DIV_STEP;
                if (i_stat.step_last) n_state = S_DIV2;
            end
            S_DIV2: begin
                w_op    = gbcd_pkg::OP_DIV2_LD;
                n_state = S_DIV2_RUN;
            end
            S_DIV2_RUN: begin
                w_op = gbcd_pkg::OP_DIV_STEP;
                if (i_stat.step_last) n_state = S_ROOT;
            end
            S_ROOT: begin
                w_op    = gbcd_pkg::OP_SQRT_LD;
                n_state = S_ROOT_RUN;
            end
            S_ROOT_RUN: begin
                w_op = gbcd_pkg::OP_SQRT_STEP;
                if (i_stat.step_last) n_state = S_DBW;
            end
            S_DBW: begin
                w_op = gbcd_pkg::OP_DB_WR;
                if (r_axis == 2'd2) begin
                    n_state = S_FIN;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_LDMEAN;
                end
            end
            S_FIN: begin
                w_op    = gbcd_pkg::OP_FINISH;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    w_op    = gbcd_pkg::OP_OUT_CAL;
                    n_state = S_IDLE;
                end
            end
            S_MEAS1: begin
                w_op    = gbcd_pkg::OP_MEAS1;
                n_state = S_MEAS2;
            end
            S_MEAS2: begin
                w_op    = gbcd_pkg::OP_MEAS2;
                n_state = S_MOUT;
            end
            S_MOUT: begin
                if (i_stat.out_free) begin
                    w_op    = gbcd_pkg::OP_OUT_MEAS;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd.op   = w_op;
    assign o_cmd.axis = r_axis;

endmodule

FILE: sv/gbcd_dp.sv
// Datapath: accumulators, serial divider, multiplier and root, measure lanes.
module gbcd_dp #(
    parameter int MAX_SAMPLES = gbcd_pkg::MAX_SAMPLES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gbcd_pkg::t_cmd                     i_cmd,
    output gbcd_pkg::t_stat                    o_stat,
    input  logic [gbcd_pkg::IN_TDATA_W-1:0]    i_in_data,
    input  logic                               i_cfg_we,
    input  logic [gbcd_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  logic [gbcd_pkg::CFG_DW-1:0]        i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [gbcd_pkg::OUT_TDATA_W-1:0]   o_out_data,
    output logic                               o_out_calibrated
);

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SW  = 16 + CW;
    localparam int QW  = 30 + CW;
    localparam int PW  = QW + CW;
    localparam int NW  = PW + 16;
    localparam int EW  = (PW > 2 * SW) ? PW : 2 * SW;
    localparam int SCW = $clog2(NW + 1);
    localparam int RW  = gbcd_pkg::ROOT_W;
    localparam int VW  = gbcd_pkg::VAR_W;
    localparam int MW  = 25;
    localparam int PRW = MW + 16;
    localparam int ZR_W_L = gbcd_pkg::ZR_W;

    // configuration
    logic [12:0] r_sample_count;
    logic [3:0]  r_sigma;
    logic [15:0] r_sens;

    // state
    logic [CW-1:0]        r_cnt;
    logic                 r_finish;
    logic signed [SW-1:0] r_sum [3];
    logic [QW-1:0]        r_sqs [3];
    logic signed [gbcd_pkg::ZR_W-1:0] r_zr [3];
    logic [gbcd_pkg::DB_W-1:0]        r_db [3];
    logic                 r_done;

    logic signed [15:0]   r_raw [3];

    // shared serial units
    logic [SCW-1:0] r_step;
    logic [NW-1:0]  r_num;
    logic [CW:0]    r_rem;
    logic [SW-1:0]  r_mag;
    logic           r_sneg;
    logic [PW-1:0]  r_mcand;
    logic [CW-1:0]  r_mplier;
    logic [PW-1:0]  r_prod;
    logic [2*SW-1:0] r_msq;
    logic [VW-1:0]  r_sq_x;
    logic [RW+2:0]  r_sq_rem;
    logic [RW-1:0]  r_root;

    // measure lanes
    logic [MW-1:0]  r_mmag [3];
    logic           r_mneg [3];
    logic [PRW-1:0] r_mprod [3];

    logic                       r_out_valid;
    logic [gbcd_pkg::RATE_W-1:0] r_rate [3];
    logic                       r_out_cal;

    logic [CW-1:0] w_target;
    logic          w_out_free;
    logic          w_out_load;
    logic [1:0]    w_ax;
    logic [CW:0]   w_rem2;
    logic          w_div_ge;
    logic [RW+2:0] w_remt;
    logic [RW+2:0] w_trial;
    logic          w_sq_ge;
    logic [SW-1:0] w_smag;
    logic [24:0]   w_qr;
    logic [ZR_W_L-1:0] w_q;
    logic [EW-1:0] w_pe;
    logic [EW-1:0] w_se;
    logic [EW-1:0] w_d;

    assign w_ax = i_cmd.axis;

    always_comb begin
        if (r_sample_count == 13'd0) begin
            w_target = CW'(1);
        end else if (32'(r_sample_count) >= 32'(MAX_SAMPLES)) begin
            w_target = CW'(MAX_SAMPLES);
        end else begin
            w_target = CW'(r_sample_count);
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_out_load = (i_cmd.op == gbcd_pkg::OP_OUT_CAL) ||
                        (i_cmd.op == gbcd_pkg::OP_OUT_MEAS);

    // restoring division by the sample count, one quotient bit per step
    assign w_rem2   = {r_rem[CW-1:0], r_num[NW-1]};
    assign w_div_ge = (w_rem2 >= {1'b0, r_cnt});

    // restoring square root, one result bit per step
    assign w_remt  = {r_sq_rem[RW:0], r_sq_x[VW-1:VW-2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_sq_ge = (w_remt >= w_trial);

    assign w_smag = r_sum[w_ax][SW-1] ? SW'(-r_sum[w_ax]) : SW'(r_sum[w_ax]);
    assign w_qr   = r_num[24:0] + 25'd1;
    assign w_q    = w_qr[24:1];

    assign w_pe = EW'(r_prod);
    assign w_se = EW'(r_msq);
    assign w_d  = (w_pe > w_se) ? (w_pe - w_se) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= gbcd_pkg::SAMPLE_COUNT_RST;
            r_sigma        <= gbcd_pkg::SIGMA_MULTIPLE_RST;
            r_sens         <= gbcd_pkg::SENSITIVITY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                gbcd_pkg::REG_SAMPLE_COUNT:   r_sample_count <= i_cfg_data[12:0];
                gbcd_pkg::REG_SIGMA_MULTIPLE: r_sigma        <= i_cfg_data[3:0];
                gbcd_pkg::REG_SENSITIVITY:    r_sens         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_finish    <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_rem       <= '0;
            r_sq_rem    <= '0;
            r_root      <= '0;
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= '0;
                r_sqs[k] <= '0;
                r_zr[k]  <= '0;
                r_db[k]  <= '0;
            end
        end else begin
            if (r_out_valid && i_out_ready && !w_out_load) r_out_valid <= 1'b0;
            unique case (i_cmd.op)
                gbcd_pkg::OP_CAPTURE: begin
                    r_raw[0] <= i_in_data[15:0];
                    r_raw[1] <= i_in_data[31:16];
                    r_raw[2] <= i_in_data[47:32];
                end
                gbcd_pkg::OP_ACCUM: begin
                    for (int k = 0; k < 3; k++) begin
                        r_sum[k] <= r_sum[k] + SW'(r_raw[k]);
                        r_sqs[k] <= r_sqs[k] + QW'($unsigned(32'(r_raw[k] * r_raw[k])));
                    end
                    r_cnt    <= r_cnt + CW'(1);
                    r_finish <= ((CW + 1)'(r_cnt) + (CW + 1)'(1)) >= (CW + 1)'(w_target);
                end
                gbcd_pkg::OP_MEAN_LD: begin
                    r_mag  <= w_smag;
                    r_sneg <= r_sum[w_ax][SW-1];
                    r_num  <= NW'(w_smag) << 9;
                    r_rem  <= '0;
                    r_step <= SCW'(NW);
                end
                gbcd_pkg::OP_DIV_STEP: begin
                    r_rem  <= w_div_ge ? (w_rem2 - {1'b0, r_cnt}) : w_rem2;
                    r_num  <= {r_num[NW-2:0], w_div_ge};
                    r_step <= r_step - SCW'(1);
                end
                gbcd_pkg::OP_MEAN_WR: begin
                    r_zr[w_ax] <= r_sneg ? -$signed(w_q) : $signed(w_q);
                    r_mcand    <= PW'(r_sqs[w_ax]);
                    r_mplier   <= r_cnt;
                    r_prod     <= '0;
                    r_step     <= SCW'(CW);
                end
                gbcd_pkg::OP_MUL_STEP: begin
                    if (r_mplier[0]) r_prod <= r_prod + r_mcand;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_step   <= r_step - SCW'(1);
                end
                gbcd_pkg::OP_SQ: begin
                    r_msq <= r_mag * r_mag;
                end
                gbcd_pkg::OP_DIFF_LD: begin
                    r_num  <= NW'(w_d[PW-1:0]) << 16;
                    r_rem  <= '0;
                    r_step <= SCW'(NW);
                end
                gbcd_pkg::OP_DIV2_LD: begin
                    r_rem  <= '0;
                    r_step <= SCW'(NW);
                end
                gbcd_pkg::OP_SQRT_LD: begin
                    r_sq_x   <= r_num[VW-1:0];
                    r_sq_rem <= '0;
                    r_root   <= '0;
                    r_step   <= SCW'(RW);
                end
                gbcd_pkg::OP_SQRT_STEP: begin
                    r_sq_rem <= w_sq_ge ? (w_remt - w_trial) : w_remt;
                    r_root   <= {r_root[RW-2:0], w_sq_ge};
                    r_sq_x   <= r_sq_x << 2;
                    r_step   <= r_step - SCW'(1);
                end
                gbcd_pkg::OP_DB_WR: begin
                    r_db[w_ax]  <= gbcd_pkg::DB_W'(r_root) * gbcd_pkg::DB_W'(r_sigma);
                    r_sum[w_ax] <= '0;
                    r_sqs[w_ax] <= '0;
                end
                gbcd_pkg::OP_FINISH: begin
                    r_cnt    <= '0;
                    r_finish <= 1'b0;
                    r_done   <= 1'b1;
                end
                gbcd_pkg::OP_OUT_CAL: begin
                    r_out_valid <= 1'b1;
                    r_out_cal   <= r_done;
                    for (int k = 0; k < 3; k++) r_rate[k] <= '0;
                end
                gbcd_pkg::OP_OUT_MEAS: begin
                    r_out_valid <= 1'b1;
                    r_out_cal   <= r_done;
                    for (int k = 0; k < 3; k++) r_rate[k] <= meas_rate(r_mprod[k], r_mneg[k]);
                end
                default: ;
            endcase
        end
    end

    // measure lanes: subtract zero rate and apply deadband, then scale
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == gbcd_pkg::OP_MEAS1) begin
            for (int k = 0; k < 3; k++) begin
                logic signed [25:0] d;
                logic [25:0]        m;
                d = 26'($signed({r_raw[k], 8'd0})) - 26'(r_zr[k]);
                m = d[25] ? 26'(-d) : 26'(d);
                r_mneg[k] <= d[25];
                r_mmag[k] <= (28'(m) < r_db[k]) ? '0 : m[MW-1:0];
            end
        end
        if (i_cmd.op == gbcd_pkg::OP_MEAS2) begin
            for (int k = 0; k < 3; k++) r_mprod[k] <= r_mmag[k] * r_sens;
        end
    end

    function automatic logic [gbcd_pkg::RATE_W-1:0] meas_rate(
        input logic [PRW-1:0] prod,
        input logic           neg
    );
        logic [PRW:0]   rs;
        logic [PRW-16:0] res;
        rs  = (PRW + 1)'(prod) + (PRW + 1)'(32768);
        res = rs[PRW:16];
        if (neg) begin
            if (res > (PRW - 15)'(2097152)) res = (PRW - 15)'(2097152);
            meas_rate = gbcd_pkg::RATE_W'(-res);
        end else begin
            if (res > (PRW - 15)'(2097151)) res = (PRW - 15)'(2097151);
            meas_rate = gbcd_pkg::RATE_W'(res);
        end
    endfunction

    assign o_stat.finish    = r_finish;
    assign o_stat.step_last = (r_step == SCW'(1));
    assign o_stat.out_free  = w_out_free;

    assign o_out_valid      = r_out_valid;
    assign o_out_data       = {6'd0, r_rate[2], r_rate[1], r_rate[0]};
    assign o_out_calibrated = r_out_cal;

`ifndef NO_ASSERTIONS
    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == gbcd_pkg::OP_DIV_STEP) |-> (r_rem < {1'b0, r_cnt}))
        else $error("divider remainder not below sample count");
    a_sqrt_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == gbcd_pkg::OP_SQRT_STEP) |-> (r_sq_rem <= {2'b0, r_root, 1'b0}))
        else $error("root remainder out of range");
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_done))
        else $error("calibration flag dropped");
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == gbcd_pkg::OP_FINISH) |=> (r_cnt == '0 && r_done))
        else $error("run end did not clear sample counter");
`endif

endmodule

FILE: sv/gyro_bias_calibrate_deadband.sv
// Top level of the gyro bias and noise calibration block with deadband.
//
//  channel   direction  handshake          payload
//  s_axis    in         tvalid/tready      tdata raw x,y,z; tuser mode
//  m_axis    out        tvalid/tready      tdata rate x,y,z; tuser calibrated
//  cfg       in         i_cfg_we           i_cfg_addr, i_cfg_data
//
// Each item, calibration sample or measure, is handled one at a time: input is
// accepted again only when the block is back in idle. The sample that ends a
// run takes longer, mostly in the bit-serial divider by the count, NW = 72 and
// CW = 13 at 4096 samples.
// Synchronous active-low reset restores the configuration defaults and clears all calibration state.
// A held result does not block input: the next item is taken and waits only
// when its result is ready and the output register is still full.
module gyro_bias_calibrate_deadband #(
    parameter int MAX_SAMPLES = gbcd_pkg::MAX_SAMPLES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [gbcd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // raw_x, raw_y, raw_z
    input  logic                             s_axis_tuser,  // mode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [gbcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // rate_x, rate_y, rate_z, pad
    output logic                             m_axis_tuser,  // calibrated
    input  logic                             i_cfg_we,
    input  logic [gbcd_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [gbcd_pkg::CFG_DW-1:0]      i_cfg_data
);

    gbcd_pkg::t_cmd  w_cmd;
    gbcd_pkg::t_stat w_stat;

    gbcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    gbcd_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_in_data        (s_axis_tdata),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_out_data       (m_axis_tdata),
        .o_out_calibrated (m_axis_tuser)
    );

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the gyro bias calibration block with deadband.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [gbcd_pkg::CFG_AW-1:0] REG_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 8000000;
    localparam int SETTLE_CYCLES = 800;

    typedef struct packed {
        logic [2:0][gbcd_pkg::RATE_W-1:0] rate;
        logic                             calibrated;
    } t_gyro_rate;

    class t_gyro_cal_scoreboard;
        int unsigned        count_cfg, sigma_cfg, sens_cfg;
        int unsigned        taken;
        longint             axis_acc[3];
        longint unsigned    square_acc[3];
        longint             bias_q8[3];
        longint unsigned    band_q8[3];
        bit                 done;
        t_gyro_rate         pending_rates[$];
        int                 errors;

        function new();
            count_cfg = gbcd_pkg::SAMPLE_COUNT_RST;
            sigma_cfg = gbcd_pkg::SIGMA_MULTIPLE_RST;
            sens_cfg  = gbcd_pkg::SENSITIVITY_RST;
            taken = 0;
            done = 0;
            errors = 0;
            for (int k = 0; k < 3; k++) begin
                axis_acc[k] = 0;
                square_acc[k] = 0;
                bias_q8[k] = 0;
                band_q8[k] = 0;
            end
        endfunction

        function void set_reg(logic [gbcd_pkg::CFG_AW-1:0] idx,
                              logic [gbcd_pkg::CFG_DW-1:0] val);
            unique case (idx)
                gbcd_pkg::REG_SAMPLE_COUNT:   count_cfg = val[12:0];
                gbcd_pkg::REG_SIGMA_MULTIPLE: sigma_cfg = val[3:0];
                gbcd_pkg::REG_SENSITIVITY:    sens_cfg  = val;
                default: ;
            endcase
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r, t;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) r = t;
            end
            return r;
        endfunction

        // Close the run: mean and spread per axis from the exact sums.
        function void close_run();
            longint unsigned n, n2, mag, q, prod, sqm, dv, v;
            n = taken;
            n2 = n * n;
            for (int k = 0; k < 3; k++) begin
                mag  = axis_acc[k] < 0 ? -axis_acc[k] : axis_acc[k];
                q    = (2 * (mag << 8) + n) / (2 * n);
                prod = n * square_acc[k];
                sqm  = mag * mag;
                dv   = prod > sqm ? prod - sqm : 0;
                v    = (dv / n2) * 65536 + ((dv % n2) * 65536) / n2;
                bias_q8[k] = axis_acc[k] < 0 ? -longint'(q) : longint'(q);
                band_q8[k] = root_floor(v) * sigma_cfg;
                axis_acc[k] = 0;
                square_acc[k] = 0;
            end
            taken = 0;
            done = 1;
        endfunction

        function void note_input(bit mode, logic [2:0][gbcd_pkg::RAW_W-1:0] raw);
            t_gyro_rate      exp_r;
            int unsigned     target;
            longint          s, dlt;
            longint unsigned mag, res;
            exp_r = '0;
            if (mode) begin
                target = count_cfg == 0 ? 1 : count_cfg;
                if (target > gbcd_pkg::MAX_SAMPLES_DEF) target = gbcd_pkg::MAX_SAMPLES_DEF;
                for (int k = 0; k < 3; k++) begin
                    s = longint'($signed(raw[k]));
                    axis_acc[k] += s;
                    square_acc[k] += longint'(s * s);
                end
                taken++;
                if (taken >= target) close_run();
            end else begin
                for (int k = 0; k < 3; k++) begin
                    dlt = longint'($signed(raw[k])) * 256 - bias_q8[k];
                    mag = dlt < 0 ? -dlt : dlt;
                    if (mag < band_q8[k]) mag = 0;
                    res = (mag * sens_cfg + 32768) >> 16;
                    if (dlt < 0) begin
                        if (res > 2097152) res = 2097152;
                        exp_r.rate[k] = gbcd_pkg::RATE_W'(-res);
                    end else begin
                        if (res > 2097151) res = 2097151;
                        exp_r.rate[k] = gbcd_pkg::RATE_W'(res);
                    end
                end
            end
            exp_r.calibrated = done;
            pending_rates.push_back(exp_r);
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check(logic [gbcd_pkg::OUT_TDATA_W-1:0] tdata, logic tuser);
            t_gyro_rate e;
            if (pending_rates.size() == 0) begin
                report("result with no transaction pending");
            end else begin
                e = pending_rates.pop_front();
                for (int k = 0; k < 3; k++)
                    if (tdata[k*gbcd_pkg::RATE_W +: gbcd_pkg::RATE_W] !== e.rate[k])
                        report($sformatf("rate axis %0d got %0d exp %0d", k,
                            $signed(tdata[k*gbcd_pkg::RATE_W +: gbcd_pkg::RATE_W]),
                            $signed(e.rate[k])));
                if (tuser !== e.calibrated)
                    report($sformatf("calibrated got %b exp %b", tuser, e.calibrated));
            end
        endtask
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [gbcd_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             s_axis_tuser = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [gbcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tuser;
    logic                             i_cfg_we = 1'b0;
    logic [gbcd_pkg::CFG_AW-1:0]      i_cfg_addr = '0;
    logic [gbcd_pkg::CFG_DW-1:0]      i_cfg_data = '0;

    t_gyro_cal_scoreboard sb = new();
    int     burst_left = 0;
    int     items_sent = 0;
    longint cycles = 0;
    int     rx_mode = 0;
    int     rx_hold = 0;

    gyro_bias_calibrate_deadband dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: switch between random stall patterns of m_axis_tready.
    always @(negedge i_clk) begin
        if (cycles % 256 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (cycles % 8 == 0);
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    m_axis_tready <= 1'b0;
                end else begin
                    rx_hold = $urandom_range(0, 3) == 0 ? $urandom_range(5, 40) : 0;
                    m_axis_tready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tuser);

    task send_item(bit mode, logic [gbcd_pkg::RAW_W-1:0] x, logic [gbcd_pkg::RAW_W-1:0] y,
                   logic [gbcd_pkg::RAW_W-1:0] z);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(mode, {z, y, x});
        burst_left--;
        items_sent++;
    endtask

    // Hold input until every pending result is out, then let the block settle.
    task drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_rates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task write_reg(logic [gbcd_pkg::CFG_AW-1:0] idx, logic [gbcd_pkg::CFG_DW-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function logic [gbcd_pkg::RAW_W-1:0] clip16(int v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[gbcd_pkg::RAW_W-1:0];
    endfunction

    function logic [gbcd_pkg::RAW_W-1:0] near(int center, int spread);
        return clip16(center + $signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    initial begin
        int bias[3], amp, phase_len, r;
        bit mode;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Measure with reset calibration: scaling only.
        send_item(0, 16'h7fff, 16'h8000, 16'h0000);
        send_item(0, 16'hffff, 16'h0001, 16'h8000);
        drain();
        // Zero count acts as one: every sample closes a run with no spread.
        write_reg(gbcd_pkg::REG_SAMPLE_COUNT, 16'd0);
        write_reg(gbcd_pkg::REG_SIGMA_MULTIPLE, 16'd15);
        write_reg(gbcd_pkg::REG_SENSITIVITY, 16'hffff);
        send_item(1, 16'd100, -16'sd200, 16'h7fff);
        send_item(0, 16'h7fff, 16'h8000, 16'd100);
        send_item(0, 16'd100, -16'sd200, 16'h7fff);
        drain();
        write_reg(gbcd_pkg::REG_SAMPLE_COUNT, 16'hE003);
        write_reg(gbcd_pkg::REG_SIGMA_MULTIPLE, 16'd1);
        write_reg(REG_UNUSED, 16'hffff);
        send_item(1, 16'h8000, 16'h7fff, 16'h0000);
        send_item(0, 16'd5, 16'd5, 16'd5);
        send_item(1, 16'h7fff, 16'h8000, 16'hffff);
        send_item(1, 16'h0000, 16'h0000, 16'd5);
        send_item(0, 16'h0000, 16'h4000, 16'hc000);
        drain();
        // Oversized count saturates; lowering it ends the run at the next sample.
        write_reg(gbcd_pkg::REG_SAMPLE_COUNT, 16'd4096);
        send_item(1, 16'd10, 16'd20, 16'd30);
        send_item(1, 16'd12, 16'd18, 16'd33);
        drain();
        write_reg(gbcd_pkg::REG_SAMPLE_COUNT, 16'h1fff);
        send_item(1, 16'd9, 16'd25, 16'd29);
        drain();
        write_reg(gbcd_pkg::REG_SAMPLE_COUNT, 16'd2);
        write_reg(gbcd_pkg::REG_SENSITIVITY, 16'd0);
        send_item(1, 16'd11, 16'd21, 16'd31);
        send_item(0, 16'd40, 16'd0, 16'hffff);
        drain();

        while (items_sent < 1850) begin
            r = $urandom_range(0, 9);
            write_reg(gbcd_pkg::REG_SAMPLE_COUNT, r == 0 ? 16'd0 : r == 1 ? 16'h1fff :
                                                  16'($urandom_range(1, 24)));
            write_reg(gbcd_pkg::REG_SIGMA_MULTIPLE, 16'($urandom_range(0, 15)));
            r = $urandom_range(0, 5);
            write_reg(gbcd_pkg::REG_SENSITIVITY, r == 0 ? 16'd0 : r == 1 ? 16'hffff :
                                                 16'($urandom));
            if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 16'($urandom));
            for (int k = 0; k < 3; k++) bias[k] = $signed(16'($urandom));
            amp = 1 << $urandom_range(0, 14);
            phase_len = $urandom_range(30, 90);
            repeat (phase_len) begin
                mode = $urandom_range(0, 1);
                if ($urandom_range(0, 9) == 0)
                    send_item(mode, 16'($urandom), 16'($urandom), 16'($urandom));
                else if (mode)
                    send_item(1, near(bias[0], amp), near(bias[1], amp), near(bias[2], amp));
                else
                    send_item(0, near(bias[0], 3 * amp), near(bias[1], 3 * amp),
                              near(bias[2], 3 * amp));
            end
            drain();
        end

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
